// ===== hdl/aes128_ecb_cipher_unit_assert.svh =====
// Assertion macros for the AES-128 ECB cipher unit checker.
// Depends on nothing; the user supplies i_clk and i_rst_n in scope.
`ifndef AES128_ECB_CIPHER_UNIT_ASSERT_SVH
`define AES128_ECB_CIPHER_UNIT_ASSERT_SVH

// Condition in one cycle implies an expression in the next, outside reset.
`define AES_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error("aes unit: next-cycle check failed");

// A cycle in reset implies an expression in the cycle after it.
`define AES_ASSERT_AFTER_RST(lbl, expr) \
    lbl: assert property (@(posedge i_clk) \
        (!i_rst_n) |=> (expr)) else $error("aes unit: reset check failed");

`endif

// ===== hdl/aes_pkg.sv =====
// Shared types, constants and byte functions of the AES-128 ECB cipher unit.
// Depends on nothing; used by the key store, the round unit and the top level.
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_SLOTS   = 2 * ROUND_COUNT;
    localparam int SLOT_W      = $clog2(KEY_SLOTS);
    localparam int CNT_W       = $clog2(ROUND_COUNT + 1);
    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;

    localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUND_COUNT);

    // Configuration register indexes.
    localparam logic [0:0] REG_KEY_LOW  = 1'b0;
    localparam logic [0:0] REG_KEY_HIGH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_KINV,
        S_LOAD,
        S_INIT,
        S_ROUND
    } t_fsm;

    // Write port of the round key store.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [BLOCK_W-1:0] data;
    } t_key_wr;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // MixColumns on one column; byte 0 (row 0) in bits 7:0.
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        return {xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3),
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3};
    endfunction

    // InvMixColumns on one column.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]   = c[8*i +: 8];
            x2     = xtime(a[i]);
            x4     = xtime(x2);
            x8     = xtime(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m11[0] ^ m13[1] ^ m9[2] ^ m14[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m14[0] ^ m11[1] ^ m13[2] ^ m9[3]};
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_block(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        for (int c = 0; c < 4; c++) begin
            t[32*c +: 32] = mix_col(s[32*c +: 32]);
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_mix_block(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        for (int c = 0; c < 4; c++) begin
            t[32*c +: 32] = inv_mix_col(s[32*c +: 32]);
        end
        return t;
    endfunction

    // Store slot of the round key used in a given round of either direction.
    function automatic logic [SLOT_W-1:0] key_slot(input logic inv,
                                                   input logic [CNT_W-1:0] rnd);
        logic [SLOT_W-1:0] s;
        if (!inv) begin
            s = SLOT_W'(rnd);
        end else if (rnd == '0) begin
            s = SLOT_W'(ROUND_COUNT);
        end else if (rnd == LAST_RND) begin
            s = '0;
        end else begin
            s = SLOT_W'(ROUND_COUNT) + SLOT_W'(rnd);
        end
        return s;
    endfunction

endpackage

// ===== hdl/aes_key_store.sv =====
// Round key store: 20 slots of 128 bits, one write and one registered read port.
// Depends on aes_pkg.
module aes_key_store (
    input  logic                          i_clk,
    input  aes_pkg::t_key_wr              i_wr,
    input  logic [aes_pkg::SLOT_W-1:0]    i_raddr,
    output logic [aes_pkg::BLOCK_W-1:0]   o_rdata
);

    logic [aes_pkg::BLOCK_W-1:0] r_mem [aes_pkg::KEY_SLOTS];
    logic [aes_pkg::BLOCK_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/aes_round.sv =====
// Shared AES round unit: (Inv)SubBytes, (Inv)ShiftRows, (Inv)MixColumns, AddRoundKey.
// Depends on aes_pkg.
module aes_round (
    input  logic [aes_pkg::BLOCK_W-1:0] i_state,
    input  logic [aes_pkg::BLOCK_W-1:0] i_key,
    input  logic                        i_inv,
    input  logic                        i_last,
    output logic [aes_pkg::BLOCK_W-1:0] o_state
);

    logic [aes_pkg::BLOCK_W-1:0] w_sub;
    logic [aes_pkg::BLOCK_W-1:0] w_mix;

    // Byte substitution with the row rotation; byte i is row i%4 of column i/4.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (!i_inv) begin
                    w_sub[8*(4*c+r) +: 8] =
                        aes_pkg::SBOX[i_state[8*(4*((c+r)%4)+r) +: 8]];
                end else begin
                    w_sub[8*(4*c+r) +: 8] =
                        aes_pkg::INV_SBOX[i_state[8*(4*((c+4-r)%4)+r) +: 8]];
                end
            end
        end
    end

    // Column mixing is skipped in the final round.
    always_comb begin
        if (i_last) begin
            w_mix = w_sub;
        end else if (i_inv) begin
            w_mix = aes_pkg::inv_mix_block(w_sub);
        end else begin
            w_mix = aes_pkg::mix_block(w_sub);
        end
    end

    assign o_state = w_mix ^ i_key;

endmodule

// ===== hdl/aes128_ecb_cipher_unit.sv =====
// Top level of the AES-128 ECB cipher unit: sequencer, key schedule and stream ports.
// Depends on aes_pkg, aes_key_store and aes_round.
//
//  Channel  Direction  Beat contents
//  s        in         tdata: block_low[63:0], block_high[127:64]; tuser: op
//  m        out        tdata: result_low[63:0], result_high[127:64]
//  cfg      in         index 0 key_low, index 1 key_high
//
// With the round keys in place a block goes through one key fetch, the initial
// key addition and ten rounds before its result is loaded; only then is the
// next input beat taken, and it can come together with the result beat.
// After reset or a key write, the next block first rebuilds the key store:
// the 11 forward keys, then the 9 inverse-cipher keys.
// A stalled result stays in the output register; the last round waits for it.
// Reset is synchronous and active low.
module aes128_ecb_cipher_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_wr_en,
    input  logic [0:0]                  i_cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [aes_pkg::BLOCK_W-1:0] i_s_tdata,   // block_low, block_high
    input  logic [0:0]                  i_s_tuser,   // op
    // Output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [aes_pkg::BLOCK_W-1:0] o_m_tdata    // result_low, result_high
);

    aes_pkg::t_fsm                  r_fsm, n_fsm;
    logic [aes_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [aes_pkg::BLOCK_W-1:0]    r_blk;
    logic                           r_op;
    logic [aes_pkg::BLOCK_W-1:0]    r_rk, n_rk;
    logic [7:0]                     r_rcon, n_rcon;
    logic                           r_keys_ready, n_keys_ready;
    logic [aes_pkg::HALF_W-1:0]     r_key_lo, r_key_hi;
    logic [aes_pkg::BLOCK_W-1:0]    r_state, n_state;
    logic                           r_out_valid, n_out_valid;
    logic [aes_pkg::BLOCK_W-1:0]    r_out_data, n_out_data;

    aes_pkg::t_key_wr               w_kwr;
    logic [aes_pkg::SLOT_W-1:0]     w_raddr;
    logic [aes_pkg::BLOCK_W-1:0]    w_rdata;
    logic [aes_pkg::BLOCK_W-1:0]    w_round;
    logic [aes_pkg::BLOCK_W-1:0]    w_next_key;
    logic                           w_last;
    logic                           w_in_beat;
    logic                           w_out_free;

    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last     = (r_cnt == aes_pkg::LAST_RND);

    aes_key_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_kwr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    aes_round u_round (
        .i_state (r_state),
        .i_key   (w_rdata),
        .i_inv   (r_op),
        .i_last  (w_last),
        .o_state (w_round)
    );

    // Next forward round key from the previous one.
    always_comb begin
        logic [31:0] t;
        for (int i = 0; i < 4; i++) begin
            t[8*i +: 8] = aes_pkg::SBOX[r_rk[8*(12 + ((i + 1) % 4)) +: 8]];
        end
        t[7:0] = t[7:0] ^ r_rcon;
        w_next_key[31:0]   = r_rk[31:0] ^ t;
        w_next_key[63:32]  = r_rk[63:32] ^ w_next_key[31:0];
        w_next_key[95:64]  = r_rk[95:64] ^ w_next_key[63:32];
        w_next_key[127:96] = r_rk[127:96] ^ w_next_key[95:64];
    end

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                aes_pkg::REG_KEY_LOW:  r_key_lo <= i_cfg_wdata;
                aes_pkg::REG_KEY_HIGH: r_key_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= aes_pkg::S_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fsm        <= n_fsm;
            r_cnt        <= n_cnt;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_blk <= i_s_tdata;
            r_op  <= i_s_tuser[0];
        end
        r_rk       <= n_rk;
        r_rcon     <= n_rcon;
        r_state    <= n_state;
        r_out_data <= n_out_data;
    end

    // Sequencer: key rebuild, key fetch, initial addition, rounds.
    always_comb begin
        n_fsm        = r_fsm;
        n_cnt        = r_cnt;
        n_rk         = r_rk;
        n_rcon       = r_rcon;
        n_keys_ready = r_keys_ready;
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        o_s_tready   = 1'b0;
        w_kwr        = '0;
        w_raddr      = '0;

        case (r_fsm)
            aes_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (w_in_beat) begin
                    n_cnt = '0;
                    n_fsm = r_keys_ready ? aes_pkg::S_LOAD : aes_pkg::S_KEXP;
                end
            end
            aes_pkg::S_KEXP: begin
                w_kwr.we   = 1'b1;
                w_kwr.addr = aes_pkg::SLOT_W'(r_cnt);
                if (r_cnt == '0) begin
                    w_kwr.data = {r_key_hi, r_key_lo};
                    n_rcon     = 8'h01;
                end else begin
                    w_kwr.data = w_next_key;
                    n_rcon     = aes_pkg::xtime(r_rcon);
                end
                n_rk = w_kwr.data;
                if (w_last) begin
                    n_cnt = aes_pkg::CNT_W'(1);
                    n_fsm = aes_pkg::S_KINV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            aes_pkg::S_KINV: begin
                // Read a forward key, store its InvMixColumns in the next cycle.
                w_raddr    = aes_pkg::SLOT_W'(aes_pkg::ROUND_COUNT) -
                             aes_pkg::SLOT_W'(r_cnt);
                w_kwr.we   = (r_cnt != aes_pkg::CNT_W'(1));
                w_kwr.addr = aes_pkg::SLOT_W'(aes_pkg::ROUND_COUNT) +
                             aes_pkg::SLOT_W'(r_cnt) - 1'b1;
                w_kwr.data = aes_pkg::inv_mix_block(w_rdata);
                if (w_last) begin
                    n_keys_ready = 1'b1;
                    n_fsm        = aes_pkg::S_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            aes_pkg::S_LOAD: begin
                w_raddr = aes_pkg::key_slot(r_op, '0);
                n_fsm   = aes_pkg::S_INIT;
            end
            aes_pkg::S_INIT: begin
                w_raddr = aes_pkg::key_slot(r_op, aes_pkg::CNT_W'(1));
                n_state = r_blk ^ w_rdata;
                n_cnt   = aes_pkg::CNT_W'(1);
                n_fsm   = aes_pkg::S_ROUND;
            end
            aes_pkg::S_ROUND: begin
                if (w_last) begin
                    // Hold the last key on the read port while the output stalls.
                    w_raddr = aes_pkg::key_slot(r_op, r_cnt);
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = w_round;
                        n_fsm       = aes_pkg::S_IDLE;
                    end
                end else begin
                    w_raddr = aes_pkg::key_slot(r_op, r_cnt + 1'b1);
                    n_state = w_round;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            default: begin
                n_fsm = aes_pkg::S_IDLE;
            end
        endcase

        // A key write invalidates the stored schedule.
        if (i_cfg_wr_en) begin
            n_keys_ready = 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/aes_checker.sv =====
// Port-level checker for the AES-128 ECB cipher unit, bound to the top level.
// Depends on aes128_ecb_cipher_unit_assert.svh and aes_pkg.
`include "aes128_ecb_cipher_unit_assert.svh"

module aes_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [aes_pkg::BLOCK_W-1:0] o_m_tdata
);

    // A stalled result stays valid.
    `AES_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // A stalled result keeps its data.
    `AES_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))

    // One block at a time: the unit is busy right after an input beat.
    `AES_ASSERT_NEXT(a_busy_after_beat, i_s_tvalid && o_s_tready, !o_s_tready)

    // No result comes straight out of reset, and the input is ready.
    `AES_ASSERT_AFTER_RST(a_rst_idle, !o_m_tvalid && o_s_tready)

endmodule

bind aes128_ecb_cipher_unit aes_checker u_aes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/sv/aes128_ecb_cipher_unit_test.sv =====
// Self-checking testbench of the AES-128 ECB cipher unit.
// Depends on aes_pkg for the register indexes; predicts every block itself.
`timescale 1ns / 1ps

module aes128_ecb_cipher_unit_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef logic [7:0] t_state [16];

    // Expected result blocks in arrival order, with error tracking.
    class cipher_scoreboard;
        logic [127:0] pending_blocks [$];
        int           error_count;

        function void note_block(logic [127:0] expected);
            pending_blocks.push_back(expected);
        endfunction

        function void check_block(logic [127:0] actual);
            logic [127:0] expected;
            if (pending_blocks.size() == 0) begin
                $error("unexpected result beat: %h", actual);
                error_count++;
                return;
            end
            expected = pending_blocks.pop_front();
            if (actual[63:0] !== expected[63:0]) begin
                $error("result_low expected %h actual %h", expected[63:0], actual[63:0]);
                error_count++;
            end
            if (actual[127:64] !== expected[127:64]) begin
                $error("result_high expected %h actual %h",
                       expected[127:64], actual[127:64]);
                error_count++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [0:0]   i_cfg_index;
    logic [63:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;   // block_low, block_high
    logic [0:0]   i_s_tuser;   // op
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;   // result_low, result_high

    cipher_scoreboard board;
    logic [7:0]   fwd_sbox [256];
    logic [7:0]   rev_sbox [256];
    logic [63:0]  key_lo_copy, key_hi_copy;
    logic [127:0] round_keys [20];
    bit           schedule_valid;
    bit           rx_hold;
    int           cycle_count;

    aes128_ecb_cipher_unit DUT (.*);

    // Free-running clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Build the substitution tables from the GF(2^8) inverse and affine map.
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic void build_sbox();
        logic [7:0] inv, v;
        for (int x = 0; x < 256; x++) begin
            inv = 0;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sbox[x] = v;
            rev_sbox[v] = x[7:0];
        end
    endfunction

    function automatic void mix_state(ref t_state s, input bit inverse);
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            if (!inverse) begin
                s[4*c]   = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
                s[4*c+1] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
                s[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
                s[4*c+3] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
            end else begin
                s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
            end
        end
    endfunction

    function automatic void sub_shift_state(ref t_state s, input bit inverse);
        t_state t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (!inverse) t[4*c+r] = fwd_sbox[s[4*((c+r)%4)+r]];
                else t[4*((c+r)%4)+r] = rev_sbox[s[4*c+r]];
            end
        end
        s = t;
    endfunction

    function automatic void xor_key(ref t_state s, input int slot);
        for (int i = 0; i < 16; i++) s[i] ^= round_keys[slot][8*i +: 8];
    endfunction

    // Forward schedule followed by the inverse-cipher inner keys.
    function automatic void expand_schedule();
        t_state k;
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [127:0] key_full;
        rc = 8'h01;
        key_full = {key_hi_copy, key_lo_copy};
        for (int i = 0; i < 16; i++) k[i] = key_full[8*i +: 8];
        for (int i = 0; i < 16; i++) round_keys[0][8*i +: 8] = k[i];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 4; i++) t[i] = fwd_sbox[k[12 + ((i+1)%4)]];
            t[0] ^= rc;
            rc = gf_mul(rc, 2);
            for (int i = 0; i < 16; i++) k[i] ^= (i < 4) ? t[i] : k[i-4];
            for (int i = 0; i < 16; i++) round_keys[r][8*i +: 8] = k[i];
        end
        for (int r = 11; r < 20; r++) begin
            for (int i = 0; i < 16; i++) k[i] = round_keys[20 - r][8*i +: 8];
            mix_state(k, 1'b1);
            for (int i = 0; i < 16; i++) round_keys[r][8*i +: 8] = k[i];
        end
        schedule_valid = 1'b1;
    endfunction

    function automatic logic [127:0] predict_block(bit decrypt, logic [127:0] blk);
        t_state s;
        logic [127:0] res;
        if (!schedule_valid) expand_schedule();
        for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8];
        if (!decrypt) begin
            xor_key(s, 0);
            for (int j = 1; j < 10; j++) begin
                sub_shift_state(s, 1'b0);
                mix_state(s, 1'b0);
                xor_key(s, j);
            end
            sub_shift_state(s, 1'b0);
            xor_key(s, 10);
        end else begin
            xor_key(s, 10);
            for (int j = 1; j < 10; j++) begin
                sub_shift_state(s, 1'b1);
                mix_state(s, 1'b1);
                xor_key(s, 10 + j);
            end
            sub_shift_state(s, 1'b1);
            xor_key(s, 0);
        end
        for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Write one key register; only called while the unit is idle.
    task automatic write_key(logic [0:0] index, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = value;
        if (index == aes_pkg::REG_KEY_LOW) key_lo_copy = value;
        else key_hi_copy = value;
        schedule_valid = 1'b0;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Offer one block and wait for its input beat.
    task automatic send_block(bit decrypt, logic [127:0] blk, int gap);
        repeat (gap) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = blk;
        i_s_tuser  = decrypt;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_block(predict_block(decrypt, blk));
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (board.pending_blocks.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_random(int count, int mode);
        logic [127:0] blk;
        for (int n = 0; n < count; n++) begin
            blk = {rand64(), rand64()};
            if ($urandom_range(0, 9) == 0) blk = {128{$urandom_range(0, 1) == 1}};
            send_block($urandom_range(0, 1), blk, (mode == 0) ? $urandom_range(0, 8) : 0);
        end
    endtask

    // Receiver: random ready gaps, or a long hold-off when requested.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            i_m_tready = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
            if (!i_m_tready) begin
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
        end
    end

    // Result beats are checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_block(o_m_tdata);
    end

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("aes128_ecb_cipher_unit regression: fail");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        board = new();
        build_sbox();
        rx_hold = 1'b0;
        key_lo_copy = 0;
        key_hi_copy = 0;
        schedule_valid = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = aes_pkg::REG_KEY_LOW;
        i_cfg_wdata = 0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 0;
        i_s_tuser = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Blocks before any key write use the all-zero key.
        send_block(1'b0, 128'h0, 0);
        send_block(1'b1, 128'h0, 1);
        send_block(1'b0, {128{1'b1}}, 0);
        send_block(1'b1, {128{1'b1}}, 3);
        drain_results();

        // Standard test key, then encrypt and decrypt a known vector.
        write_key(aes_pkg::REG_KEY_LOW, 64'ha6d2ae2816157e2b);
        write_key(aes_pkg::REG_KEY_HIGH, 64'h3c4fcf098815f7ab);
        send_block(1'b0, 128'h340737e0a29831318d305a88a8f64332, 0);
        send_block(1'b1, 128'h320b6a19978511dcfb09dc021d842539, 0);
        send_block(1'b0, 128'h0, 2);
        send_block(1'b1, {128{1'b1}}, 0);
        drain_results();

        // Extreme keys.
        write_key(aes_pkg::REG_KEY_LOW, {64{1'b1}});
        write_key(aes_pkg::REG_KEY_HIGH, {64{1'b1}});
        send_block(1'b0, {128{1'b1}}, 0);
        send_block(1'b1, 128'h0, 0);
        send_block(1'b0, 128'h1, 0);
        drain_results();
        write_key(aes_pkg::REG_KEY_HIGH, 64'h0);
        send_block(1'b1, 128'h8000_0000_0000_0000_0000_0000_0000_0000, 0);
        send_block(1'b0, 128'h0, 0);
        drain_results();

        // Random phases, each with a fresh key.
        for (int phase = 0; phase < 6; phase++) begin
            write_key(aes_pkg::REG_KEY_LOW, rand64());
            write_key(aes_pkg::REG_KEY_HIGH, rand64());
            if (phase == 2) rx_hold = 1'b1;
            send_random(100, (phase == 3) ? 1 : 0);
            drain_results();
        end

        drain_results();
        if (board.error_count == 0 && board.pending_blocks.size() == 0) begin
            $display("aes128_ecb_cipher_unit regression: pass");
        end else begin
            $display("aes128_ecb_cipher_unit regression: fail");
        end
        $finish;
    end

endmodule
